// File: rtl/tic_pkg.sv
`default_nettype none
package tic_pkg;

	// Width of a coordinate word and of one coordinate difference magnitude.
	localparam int CRD_W = 32;
	localparam int MAG_W = CRD_W + 1;

	// Side length root bits: three squares of magnitudes up to 2^32 stay below 2^66.
	localparam int SIDE_N = 33;
	localparam int SQS_W = 2 * SIDE_N;

	// Perimeter and doubled half-perimeter differences.
	localparam int PER_W = SIDE_N + 2;
	localparam int XYZ_W = PER_W;

	// Heron product, divisor 4p and quotient of the radius path.
	localparam int PROD_W = 3 * XYZ_W;
	localparam int RDIV_DW = PER_W + 2;
	localparam int RDIV_QW = 68;
	localparam int RAD_N = RDIV_QW / 2;

	// Weighted coordinate sums of the incenter path.
	localparam int WP_W = SIDE_N + 1 + CRD_W;
	localparam int WSUM_W = WP_W + 2;
	localparam int WMAG_W = WSUM_W - 1;
	localparam int IDIV_QW = CRD_W;
	localparam int IDIV_DW = PER_W;

	// Flags that travel alongside the quotient chains.
	typedef struct packed {
		logic degen;
		logic clamp;
		logic [2:0] neg;
	} tic_flags_t;

	// Magnitude of the difference of two signed coordinates.
	function automatic logic [MAG_W-1:0] mag_diff(input logic [CRD_W-1:0] p,
		input logic [CRD_W-1:0] q);
		logic [MAG_W-1:0] diff;
		diff = {p[CRD_W-1], p} - {q[CRD_W-1], q};
		return diff[MAG_W-1] ? (~diff + 1'b1) : diff;
	endfunction

endpackage
`default_nettype wire

// File: rtl/tic_delay.sv
`default_nettype none
module tic_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [WIDTH-1:0] d,
	output logic      [WIDTH-1:0] q
);

	logic [WIDTH-1:0] pipe_q [DEPTH];

	// Shift line of DEPTH registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) pipe_q[i] <= '0;
		end else begin
			pipe_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) pipe_q[i] <= pipe_q[i-1];
		end
	end

	assign q = pipe_q[DEPTH-1];

endmodule
`default_nettype wire

// File: rtl/tic_sqrt_cell.sv
`default_nettype none
module tic_sqrt_cell #(
	parameter int N = 33
) (
	input  wire logic             clk,
	input  wire logic [2*N-1:0]   rad_i,
	input  wire logic [N-1:0]     root_i,
	input  wire logic [N+1:0]     rem_i,
	output logic      [2*N-1:0]   rad_o,
	output logic      [N-1:0]     root_o,
	output logic      [N+1:0]     rem_o
);

	logic [N+1:0] rem_sh;
	logic [N+1:0] trial;
	logic         ge;

	// One root bit: bring in two radicand bits and try the odd trial value.
	assign rem_sh = {rem_i[N-1:0], rad_i[2*N-1:2*N-2]};
	assign trial  = {root_i, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		rad_o  <= {rad_i[2*N-3:0], 2'b00};
		root_o <= {root_i[N-2:0], ge};
		rem_o  <= ge ? (rem_sh - trial) : rem_sh;
	end

endmodule
`default_nettype wire

// File: rtl/tic_div_cell.sv
`default_nettype none
module tic_div_cell #(
	parameter int DW = 35,
	parameter int QW = 32
) (
	input  wire logic          clk,
	input  wire logic [DW-1:0] rem_i,
	input  wire logic [QW-1:0] nlo_i,
	input  wire logic [DW-1:0] d_i,
	output logic      [DW-1:0] rem_o,
	output logic      [QW-1:0] nlo_o,
	output logic      [DW-1:0] d_o
);

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	// One quotient bit: the next dividend bit shifts out, the quotient bit shifts in.
	assign trial = {rem_i, nlo_i[QW-1]};
	assign diff  = trial - {1'b0, d_i};
	assign ge    = (trial >= {1'b0, d_i});

	always_ff @(posedge clk) begin
		rem_o <= ge ? diff[DW-1:0] : trial[DW-1:0];
		nlo_o <= {nlo_i[QW-2:0], ge};
		d_o   <= d_i;
	end

endmodule
`default_nettype wire

// File: rtl/triangle_incircle.sv
// Inscribed circle of one 3D triangle per word.
// Input channel: vertices A, B, C (ax..cz, signed Q16.16) are taken at a rising
// edge where start is high and busy is low. busy stays low: the block is a
// fixed pipeline and takes a new triangle in every cycle.
// Output channel: done is high for exactly one cycle with radius (unsigned
// Q16.16), center_x/y/z (signed Q16.16) and degenerate. The receiver cannot
// hold results off, and none is needed since nothing ever waits.
// The pipeline is made of chains of cells: 33 square-root cells for the side
// lengths, 68 divider cells for the Heron quotient and 34 square-root cells for
// the radius, plus seven arithmetic stages and the output register.
// Throughput is one triangle per cycle.
// Results come out in the order the triangles went in.
// A triangle with zero perimeter gives degenerate=1, radius 0 and center A.
// Reset clears the valid line; results in flight are dropped.
`default_nettype none
module triangle_incircle (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] ax,
	input  wire logic [31:0] ay,
	input  wire logic [31:0] az,
	input  wire logic [31:0] bx,
	input  wire logic [31:0] by,
	input  wire logic [31:0] bz,
	input  wire logic [31:0] cx,
	input  wire logic [31:0] cy,
	input  wire logic [31:0] cz,
	output logic             done,
	output logic [31:0]      radius,
	output logic [31:0]      center_x,
	output logic [31:0]      center_y,
	output logic [31:0]      center_z,
	output logic             degenerate
);
	import tic_pkg::*;

	// Edge numbers at which each stage is loaded, counted from the accepting edge.
	localparam int E_LEN = 2 + SIDE_N;
	localparam int E_T3 = E_LEN + 3;
	localparam int E_T4 = E_T3 + 1;
	localparam int E_FIN = E_T4 + RDIV_QW + RAD_N;
	localparam int LATENCY = E_FIN + 2;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: difference magnitudes; side 0 is B-C, side 1 is A-C, side 2 is A-B.
	logic [CRD_W-1:0] va [3];
	logic [CRD_W-1:0] vb [3];
	logic [CRD_W-1:0] vc [3];
	logic             v_s1;
	logic [MAG_W-1:0] mag_s1 [9];
	logic [9*CRD_W-1:0] crd_s1;

	assign va[0] = ax; assign va[1] = ay; assign va[2] = az;
	assign vb[0] = bx; assign vb[1] = by; assign vb[2] = bz;
	assign vc[0] = cx; assign vc[1] = cy; assign vc[2] = cz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			mag_s1[k]     <= mag_diff(vb[k], vc[k]);
			mag_s1[3 + k] <= mag_diff(va[k], vc[k]);
			mag_s1[6 + k] <= mag_diff(va[k], vb[k]);
		end
		crd_s1 <= {ax, ay, az, bx, by, bz, cx, cy, cz};
	end

	// Stages 2 and 3: squares, then squared side lengths.
	logic [SQS_W-1:0] sq_s2 [9];
	logic [SQS_W-1:0] sum_s3 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) sq_s2[i] <= mag_s1[i] * mag_s1[i];
		for (int s = 0; s < 3; s++) sum_s3[s] <= sq_s2[3*s] + sq_s2[3*s+1] + sq_s2[3*s+2];
	end

	// Side lengths: one chain of square-root cells per side.
	logic [SQS_W-1:0]  srad  [3][SIDE_N+1];
	logic [SIDE_N-1:0] sroot [3][SIDE_N+1];
	logic [SIDE_N+1:0] srem  [3][SIDE_N+1];
	logic [SIDE_N-1:0] len   [3];

	for (genvar s = 0; s < 3; s++) begin : g_side
		assign srad[s][0]  = sum_s3[s];
		assign sroot[s][0] = '0;
		assign srem[s][0]  = '0;
		for (genvar i = 0; i < SIDE_N; i++) begin : g_cell
			tic_sqrt_cell #(.N(SIDE_N)) u_cell (
				.clk    (clk),
				.rad_i  (srad[s][i]),
				.root_i (sroot[s][i]),
				.rem_i  (srem[s][i]),
				.rad_o  (srad[s][i+1]),
				.root_o (sroot[s][i+1]),
				.rem_o  (srem[s][i+1])
			);
		end
		assign len[s] = sroot[s][SIDE_N];
	end

	// Coordinates wait for the side lengths.
	logic [9*CRD_W-1:0] crd_d;
	tic_delay #(.WIDTH(9*CRD_W), .DEPTH(E_LEN)) u_crd_dly (
		.clk(clk), .arst_n(arst_n), .d(crd_s1), .q(crd_d)
	);

	logic signed [CRD_W-1:0] vd [3][3];
	for (genvar j = 0; j < 3; j++) begin : g_vd
		for (genvar k = 0; k < 3; k++) begin : g_k
			assign vd[j][k] = crd_d[(8 - 3*j - k)*CRD_W +: CRD_W];
		end
	end

	// Stage t1: perimeter, doubled half-perimeter differences, weighted coordinates.
	logic [XYZ_W:0]   xs, ys, zs;
	logic [PER_W-1:0] p_t1;
	logic [XYZ_W-1:0] x_t1, y_t1, z_t1;
	logic             clamp_t1;
	logic signed [WP_W-1:0] wp_t1 [3][3];

	assign xs = {3'b000, len[1]} + {3'b000, len[2]} - {3'b000, len[0]};
	assign ys = {3'b000, len[0]} + {3'b000, len[2]} - {3'b000, len[1]};
	assign zs = {3'b000, len[0]} + {3'b000, len[1]} - {3'b000, len[2]};

	always_ff @(posedge clk) begin
		p_t1     <= {2'b00, len[0]} + {2'b00, len[1]} + {2'b00, len[2]};
		x_t1     <= xs[XYZ_W-1:0];
		y_t1     <= ys[XYZ_W-1:0];
		z_t1     <= zs[XYZ_W-1:0];
		clamp_t1 <= xs[XYZ_W] | ys[XYZ_W] | zs[XYZ_W];
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				wp_t1[j][k] <= $signed({1'b0, len[j]}) * vd[j][k];
			end
		end
	end

	// Stage t2: first Heron product and the three weighted sums.
	logic [2*XYZ_W-1:0] xy_t2;
	logic [XYZ_W-1:0]   z_t2;
	logic [PER_W-1:0]   p_t2;
	logic               clamp_t2, degen_t2;
	logic signed [WSUM_W-1:0] sum_t2 [3];

	always_ff @(posedge clk) begin
		xy_t2    <= x_t1 * y_t1;
		z_t2     <= z_t1;
		p_t2     <= p_t1;
		clamp_t2 <= clamp_t1;
		degen_t2 <= (p_t1 == '0);
		for (int k = 0; k < 3; k++) begin
			sum_t2[k] <= WSUM_W'(wp_t1[0][k]) + WSUM_W'(wp_t1[1][k]) + WSUM_W'(wp_t1[2][k]);
		end
	end

	// Stage t3: split partial products of the Heron product, sum magnitudes.
	logic [2*XYZ_W-1:0] pplo_t3, pphi_t3;
	logic [PER_W-1:0]   p_t3;
	logic [WMAG_W-1:0]  wmag_t3 [3];
	tic_flags_t         flg_t3;

	always_ff @(posedge clk) begin
		pplo_t3      <= xy_t2[XYZ_W-1:0] * z_t2;
		pphi_t3      <= xy_t2[2*XYZ_W-1:XYZ_W] * z_t2;
		p_t3         <= p_t2;
		flg_t3.degen <= degen_t2;
		flg_t3.clamp <= clamp_t2;
		for (int k = 0; k < 3; k++) begin
			flg_t3.neg[k] <= sum_t2[k][WSUM_W-1];
			wmag_t3[k]    <= sum_t2[k][WSUM_W-1] ? WMAG_W'(-sum_t2[k])
				: sum_t2[k][WMAG_W-1:0];
		end
	end

	// Stage t4: full Heron product and the divisor 4p.
	logic [PROD_W-1:0]  prod_t4;
	logic [RDIV_DW-1:0] dvs_t4;

	always_ff @(posedge clk) begin
		prod_t4 <= {pphi_t3, {XYZ_W{1'b0}}} + {{XYZ_W{1'b0}}, pplo_t3};
		dvs_t4  <= {p_t3, 2'b00};
	end

	// Radius squared: chain of divider cells for xyz / 4p.
	logic [RDIV_DW-1:0] rrem [RDIV_QW+1];
	logic [RDIV_QW-1:0] rlo  [RDIV_QW+1];
	logic [RDIV_DW-1:0] rd   [RDIV_QW+1];

	assign rrem[0] = prod_t4[PROD_W-1:RDIV_QW];
	assign rlo[0]  = prod_t4[RDIV_QW-1:0];
	assign rd[0]   = dvs_t4;

	for (genvar i = 0; i < RDIV_QW; i++) begin : g_rdiv
		tic_div_cell #(.DW(RDIV_DW), .QW(RDIV_QW)) u_cell (
			.clk(clk), .rem_i(rrem[i]), .nlo_i(rlo[i]), .d_i(rd[i]),
			.rem_o(rrem[i+1]), .nlo_o(rlo[i+1]), .d_o(rd[i+1])
		);
	end

	// Radius: chain of square-root cells over the quotient.
	logic [2*RAD_N-1:0] qrad  [RAD_N+1];
	logic [RAD_N-1:0]   qroot [RAD_N+1];
	logic [RAD_N+1:0]   qrem  [RAD_N+1];

	assign qrad[0]  = rlo[RDIV_QW];
	assign qroot[0] = '0;
	assign qrem[0]  = '0;

	for (genvar i = 0; i < RAD_N; i++) begin : g_rsqrt
		tic_sqrt_cell #(.N(RAD_N)) u_cell (
			.clk(clk), .rad_i(qrad[i]), .root_i(qroot[i]), .rem_i(qrem[i]),
			.rad_o(qrad[i+1]), .root_o(qroot[i+1]), .rem_o(qrem[i+1])
		);
	end

	// Incenter: one divider chain per coordinate, sum magnitude over p.
	logic [IDIV_DW-1:0] irem [3][IDIV_QW+1];
	logic [IDIV_QW-1:0] ilo  [3][IDIV_QW+1];
	logic [IDIV_DW-1:0] idv  [3][IDIV_QW+1];
	logic [3*IDIV_QW-1:0] iq_all, iq_d;

	for (genvar k = 0; k < 3; k++) begin : g_inc
		assign irem[k][0] = wmag_t3[k][WMAG_W-1:IDIV_QW];
		assign ilo[k][0]  = wmag_t3[k][IDIV_QW-1:0];
		assign idv[k][0]  = p_t3;
		for (genvar i = 0; i < IDIV_QW; i++) begin : g_cell
			tic_div_cell #(.DW(IDIV_DW), .QW(IDIV_QW)) u_cell (
				.clk(clk), .rem_i(irem[k][i]), .nlo_i(ilo[k][i]), .d_i(idv[k][i]),
				.rem_o(irem[k][i+1]), .nlo_o(ilo[k][i+1]), .d_o(idv[k][i+1])
			);
		end
		assign iq_all[k*IDIV_QW +: IDIV_QW] = ilo[k][IDIV_QW];
	end

	// Align the side paths with the end of the radius chain.
	tic_delay #(.WIDTH(3*IDIV_QW), .DEPTH(E_FIN - E_T3 - IDIV_QW)) u_iq_dly (
		.clk(clk), .arst_n(arst_n), .d(iq_all), .q(iq_d)
	);

	tic_flags_t flg_d;
	tic_delay #(.WIDTH($bits(tic_flags_t)), .DEPTH(E_FIN - E_T3)) u_flg_dly (
		.clk(clk), .arst_n(arst_n), .d(flg_t3), .q(flg_d)
	);

	logic [3*CRD_W-1:0] va_d;
	tic_delay #(.WIDTH(3*CRD_W), .DEPTH(E_FIN - E_LEN)) u_a_dly (
		.clk(clk), .arst_n(arst_n), .d(crd_d[9*CRD_W-1:6*CRD_W]), .q(va_d)
	);

	logic v_d;
	tic_delay #(.WIDTH(1), .DEPTH(E_FIN)) u_v_dly (
		.clk(clk), .arst_n(arst_n), .d(v_s1), .q(v_d)
	);

	// Output register: saturate the radius, restore signs, apply special cases.
	logic [RAD_N-1:0]   root_f;
	logic [IDIV_QW-1:0] qk [3];
	logic [CRD_W-1:0]   ctr [3];
	logic               done_q;
	logic [31:0]        radius_q;
	logic [CRD_W-1:0]   cx_q, cy_q, cz_q;
	logic               degen_q;

	assign root_f = qroot[RAD_N];
	for (genvar k = 0; k < 3; k++) begin : g_ctr
		assign qk[k]  = iq_d[k*IDIV_QW +: IDIV_QW];
		assign ctr[k] = flg_d.degen ? va_d[(2-k)*CRD_W +: CRD_W]
			: (flg_d.neg[k] ? (~qk[k] + 1'b1) : qk[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (flg_d.degen || flg_d.clamp) begin
			radius_q <= '0;
		end else if (root_f[RAD_N-1:32] != '0) begin
			radius_q <= '1;
		end else begin
			radius_q <= root_f[31:0];
		end
		cx_q    <= ctr[0];
		cy_q    <= ctr[1];
		cz_q    <= ctr[2];
		degen_q <= flg_d.degen;
	end

	assign done       = done_q;
	assign radius     = radius_q;
	assign center_x   = cx_q;
	assign center_y   = cy_q;
	assign center_z   = cz_q;
	assign degenerate = degen_q;

	// Every accepted word leaves after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(LATENCY) done)
		else $error("word accepted without a result after the pipeline latency");

	// No result without a word accepted at the matching edge.
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result strobe without an accepted word");

	// A degenerate triangle reports a zero radius.
	a_degen_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (radius == '0))
		else $error("degenerate triangle with nonzero radius");

endmodule
`default_nettype wire
